>>> design/tclp_pkg.sv
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types and constants of the text command line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

	localparam int LINE_CAPACITY = 256;
	localparam int PS_MAX_LEN    = 8;
	localparam int RT_MAX_LEN    = 64;

	localparam int STORE_DEPTH = 67;
	localparam int ARG_START   = 3;
	localparam int ADDR_W      = 7;
	localparam int CNT_W       = $clog2(LINE_CAPACITY);
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;

	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_P     = 8'h50;
	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] CHAR_R     = 8'h52;
	localparam logic [7:0] CHAR_T     = 8'h54;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_O     = 8'h4F;
	localparam logic [7:0] CHAR_N     = 8'h4E;

	typedef enum logic [2:0] {
		KIND_PS      = 3'd0,
		KIND_RT      = 3'd1,
		KIND_TA      = 3'd2,
		KIND_UNKNOWN = 3'd3,
		KIND_DISCARD = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SINGLE,
		S_READ,
		S_LOAD
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept_en;
		logic load_single;
		logic issue_rd;
		logic load_char;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic nl_single;
		logic nl_text;
		logic out_free;
		logic idx_last;
	} sts_t;

endpackage

>>> design/tclp_if.sv
// ----------------------------------------------------------------------------
// tclp_in_if / tclp_out_if
// Valid/ready channels for input bytes and parsed results.
// ----------------------------------------------------------------------------
interface tclp_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface tclp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [5:0] char_index;
	logic [7:0] text_char;
	logic       empty_arg;
	logic       ta_on;
	logic       last;

	modport source (output valid, output kind, output char_index, output text_char,
		output empty_arg, output ta_on, output last, input ready);
	modport sink   (input valid, input kind, input char_index, input text_char,
		input empty_arg, input ta_on, input last, output ready);
endinterface

>>> design/tclp_ctrl.sv
// ----------------------------------------------------------------------------
// tclp_ctrl
// Sequencer: byte intake, single-result dispatch, argument read-out loop.
// ----------------------------------------------------------------------------
module tclp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  tclp_pkg::sts_t sts,
	output tclp_pkg::cmd_t cmd
);
	import tclp_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept_en = 1'b1;
				if (sts.nl_text) begin
					state_d = S_READ;
				end else if (sts.nl_single) begin
					state_d = S_SINGLE;
				end
			end
			S_SINGLE: begin
				if (sts.out_free) begin
					cmd.load_single = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_READ: begin
				cmd.issue_rd = 1'b1;
				state_d      = S_LOAD;
			end
			S_LOAD: begin
				if (sts.out_free) begin
					cmd.load_char = 1'b1;
					state_d       = sts.idx_last ? S_IDLE : S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_text_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		sts.nl_text |=> state_q == S_READ)
		else $error("text line did not start read-out");

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_LOAD)
		else $error("read not followed by load");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_single |=> state_q == S_IDLE)
		else $error("single result did not return to idle");

endmodule

>>> design/tclp_dp.sv
// ----------------------------------------------------------------------------
// tclp_dp
// Line store, line tracking, prefix decode and result register.
// ----------------------------------------------------------------------------
module tclp_dp (
	input  logic           clk,
	input  logic           arst_n,
	tclp_in_if.sink        byte_stream,
	tclp_out_if.source     result,
	input  tclp_pkg::cmd_t cmd,
	output tclp_pkg::sts_t sts
);
	import tclp_pkg::*;

	logic [7:0]        line_mem [STORE_DEPTH];
	logic [7:0]        rd_data_q;
	logic [7:0]        pfx_q [5];
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  len_q;
	logic              zero_seen_q;

	kind_t             res_kind_q;
	logic [LEN_W-1:0]  res_n_q;
	logic              res_ta_q;
	logic              res_empty_q;
	logic [IDX_W-1:0]  idx_q;

	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [7:0]        out_char_q;
	logic              out_empty_q;
	logic              out_ta_q;
	logic              out_last_q;

	logic              fire, nl_fire, data_fire, close_fire;
	logic              store_en, text_ok, is_ps, is_rt, is_ta, is_text;
	logic [LEN_W-1:0]  arg_len, n_d;
	logic              ta_d, produces;
	kind_t             kind_d;
	logic [ADDR_W-1:0] rd_addr;

	assign byte_stream.ready = cmd.accept_en;
	assign fire       = byte_stream.valid && cmd.accept_en;
	assign close_fire = fire && byte_stream.command;
	assign nl_fire    = fire && !byte_stream.command && (byte_stream.data_byte == CHAR_NL);
	assign data_fire  = fire && !byte_stream.command && (byte_stream.data_byte != CHAR_NL);
	assign store_en   = data_fire && !ovf_q && (count_q < CNT_W'(LINE_CAPACITY - 1));

	// prefix decode from the tracked line state
	always_comb begin
		text_ok = (len_q >= LEN_W'(ARG_START)) && (pfx_q[2] == CHAR_SPACE);
		is_ps   = text_ok && (pfx_q[0] == CHAR_P) && (pfx_q[1] == CHAR_S);
		is_rt   = text_ok && (pfx_q[0] == CHAR_R) && (pfx_q[1] == CHAR_T);
		is_ta   = text_ok && (pfx_q[0] == CHAR_T) && (pfx_q[1] == CHAR_A);
		is_text = is_ps || is_rt;
		arg_len = len_q - LEN_W'(ARG_START);
		n_d     = '0;
		if (is_ps) begin
			n_d = (arg_len > LEN_W'(PS_MAX_LEN)) ? LEN_W'(PS_MAX_LEN) : arg_len;
		end else if (is_rt) begin
			n_d = (arg_len > LEN_W'(RT_MAX_LEN)) ? LEN_W'(RT_MAX_LEN) : arg_len;
		end
		// an overflowed line reports only the discard, never the flag
		ta_d = !ovf_q && is_ta && (len_q == LEN_W'(ARG_START + 2))
			&& (pfx_q[3] == CHAR_O) && (pfx_q[4] == CHAR_N);
		priority if (ovf_q) begin
			kind_d = KIND_DISCARD;
		end else if (is_ps) begin
			kind_d = KIND_PS;
		end else if (is_rt) begin
			kind_d = KIND_RT;
		end else if (is_ta) begin
			kind_d = KIND_TA;
		end else begin
			kind_d = KIND_UNKNOWN;
		end
		produces = ovf_q || (count_q != '0);
	end

	assign sts.nl_text   = nl_fire && !ovf_q && (count_q != '0) && is_text && (n_d != '0);
	assign sts.nl_single = nl_fire && produces && !sts.nl_text;
	assign sts.out_free  = !out_valid_q || result.ready;
	assign sts.idx_last  = (LEN_W'(idx_q) + 1'b1) == res_n_q;

	// line tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			len_q       <= '0;
			zero_seen_q <= 1'b0;
		end else if (nl_fire || close_fire) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			len_q       <= '0;
			zero_seen_q <= 1'b0;
		end else if (data_fire && !ovf_q) begin
			if (store_en) begin
				count_q <= count_q + 1'b1;
				if (int'(count_q) < STORE_DEPTH && !zero_seen_q) begin
					if (byte_stream.data_byte == 8'd0) begin
						zero_seen_q <= 1'b1;
					end else begin
						len_q <= len_q + 1'b1;
					end
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// line store and first five bytes
	always_ff @(posedge clk) begin
		if (store_en && int'(count_q) < STORE_DEPTH) begin
			line_mem[ADDR_W'(count_q)] <= byte_stream.data_byte;
		end
		if (cmd.issue_rd) begin
			rd_data_q <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (store_en && int'(count_q) < 5) begin
			pfx_q[3'(count_q)] <= byte_stream.data_byte;
		end
	end

	assign rd_addr = ADDR_W'(ARG_START) + ADDR_W'(idx_q);

	// per-line result descriptor
	always_ff @(posedge clk) begin
		if (nl_fire) begin
			res_kind_q  <= kind_d;
			res_n_q     <= n_d;
			res_ta_q    <= ta_d;
			res_empty_q <= !ovf_q && is_text && (n_d == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (nl_fire) begin
			idx_q <= '0;
		end else if (cmd.load_char) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_single || cmd.load_char) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			out_kind_q  <= res_kind_q;
			out_idx_q   <= '0;
			out_char_q  <= '0;
			out_empty_q <= res_empty_q;
			out_ta_q    <= res_ta_q;
			out_last_q  <= 1'b1;
		end else if (cmd.load_char) begin
			out_kind_q  <= res_kind_q;
			out_idx_q   <= idx_q;
			out_char_q  <= rd_data_q;
			out_empty_q <= 1'b0;
			out_ta_q    <= 1'b0;
			out_last_q  <= sts.idx_last;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kind       = out_kind_q;
	assign result.char_index = out_idx_q;
	assign result.text_char  = out_char_q;
	assign result.empty_arg  = out_empty_q;
	assign result.ta_on      = out_ta_q;
	assign result.last       = out_last_q;

	a_len_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(len_q) <= int'(count_q))
		else $error("text length beyond line count");

	a_char_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_char |-> (LEN_W'(idx_q) < res_n_q))
		else $error("argument index past its length");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_char || cmd.load_single) |-> (!out_valid_q || result.ready))
		else $error("result register overwritten");

endmodule

>>> design/text_command_line_parser_unit.sv
// ----------------------------------------------------------------------------
// text_command_line_parser_unit
// Gathers text bytes into lines and decodes PS / RT / TA commands.
// ----------------------------------------------------------------------------
// Data bytes and stream-closed transactions: one per cycle while the sequencer is idle, no result.
// Newline: one result (TA, unknown, discarded, empty argument) loads the
//   result register from the single-result state once the register is free.
// PS/RT argument: one read and one load per character, set by the line store's single
//   registered read port; input is held off until the last character loads.
// Reset clears the line count, overflow mark, sequencer and result valid;
//   the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module text_command_line_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	tclp_in_if.sink    byte_stream,
	tclp_out_if.source result
);
	import tclp_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// Sequencer: idle intake, single-result load, read/load loop per char.
	tclp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath: line store memory, count/overflow/length tracking, prefix
	// decode latched at the newline, and the result register that lets the
	// next byte transaction enter while a result still waits downstream.
	tclp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.result      (result),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
